@@ rtl/core/rdsc_pkg.sv @@
// Shared types, constants and a helper function of the radix digit string converter.
`timescale 1ns / 1ps

package rdsc_pkg;

	localparam int MAX_DIGITS_DEF = 13;
	localparam int VALUE_W        = 13;
	localparam int RADIX_W        = 6;
	localparam int DIGIT_W        = 5;
	localparam int CHAR_W         = 7;
	localparam int BIT_CNT_W      = $clog2(VALUE_W);

	localparam logic [VALUE_W-1:0]   VALUE_LIMIT = VALUE_W'(4097);
	localparam logic [RADIX_W-1:0]   RADIX_LIMIT = RADIX_W'(33);
	localparam logic [RADIX_W-1:0]   RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0]   RADIX_RESET = RADIX_W'(10);
	localparam logic [BIT_CNT_W-1:0] BIT_LAST    = BIT_CNT_W'(VALUE_W - 1);
	localparam logic [CHAR_W-1:0]    CHAR_ERROR  = '0;

	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic rd;
		logic emit;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic bit_last;
		logic q_zero;
		logic ptr_full;
		logic rd_zero;
		logic out_free;
		logic bad_radix;
	} sts_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {2'b00, d};
		if (d < DIGIT_W'(10)) begin
			return CHAR_W'(48) + dx;
		end
		return CHAR_W'(55) + dx;
	endfunction

endpackage

@@ rtl/core/radix_digit_string_converter_core.sv @@
// Top level: stream ports, radix register and controller/datapath assembly.
`timescale 1ns / 1ps

// Each digit is produced by bit-serial division and then stored; once all digits are stored,
// each digit is read back and emitted, most significant first.
// The next input transfer is taken once the last result of an item is loaded.
// Throughput is set by the one shared 13-bit divider, one quotient bit per cycle.
// Reset clears the controller and output valid and sets the radix register to 10.
module radix_digit_string_converter_core #(
	parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [12:0] value, [15:13] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
	output logic        m_tlast,
	output logic        m_tuser,   // [0] bad_radix
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rdsc_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic               cfg_wr;
	cmd_t               cmd;
	sts_t               sts;
	logic [CHAR_W-1:0]  out_char;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr && !paddr[2]) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	assign prdata = paddr[2] ? 32'd0 : {26'd0, radix_q};

	rdsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rdsc_dpath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (s_tdata[VALUE_W-1:0]),
		.radix     (radix_q),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast),
		.out_bad   (m_tuser)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

@@ rtl/core/rdsc_ctrl.sv @@
// Controller state machine that sequences division, digit storage and emission.
`timescale 1ns / 1ps

module rdsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rdsc_pkg::sts_t  sts,
	output rdsc_pkg::cmd_t  cmd
);
	import rdsc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_STORE = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_ERR   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.bad_radix ? S_ERR : S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.bit_last) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = (sts.q_zero || sts.ptr_full) ? S_READ : S_DIV;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.rd_zero ? S_IDLE : S_READ;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.div_step, cmd.store, cmd.rd, cmd.emit, cmd.emit_err}))
		else $error("More than one datapath command in a cycle.");

	a_emit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> (state_q == S_EMIT))
		else $error("A digit read was not followed by the emit state.");

	a_div_done_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.bit_last) |=> cmd.store)
		else $error("A finished division was not stored.");

endmodule

@@ rtl/core/rdsc_dpath.sv @@
// Datapath: bit-serial divider, digit memory and output register.
`timescale 1ns / 1ps

module rdsc_dpath #(
	parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rdsc_pkg::VALUE_W-1:0]  value,
	input  logic [rdsc_pkg::RADIX_W-1:0]  radix,
	input  rdsc_pkg::cmd_t                cmd,
	output rdsc_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rdsc_pkg::CHAR_W-1:0]   out_char,
	output logic                          out_last,
	output logic                          out_bad
);
	import rdsc_pkg::*;

	localparam int PTR_W = $clog2(MAX_DIGITS);

	logic [DIGIT_W-1:0]   mem_q [MAX_DIGITS];
	logic [VALUE_W-1:0]   quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [DIGIT_W-1:0]   rd_digit_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	logic [DIGIT_W:0]     rem_sh;
	logic                 sub_ok;
	logic [DIGIT_W:0]     rem_sub;

	assign rem_sh  = {rem_q, quo_q[VALUE_W-1]};
	assign sub_ok  = (rem_sh >= radix);
	assign rem_sub = rem_sh - radix;

	assign sts.bit_last  = (bit_cnt_q == BIT_LAST);
	assign sts.q_zero    = (quo_q == '0);
	assign sts.ptr_full  = (wr_ptr_q == PTR_W'(MAX_DIGITS - 1));
	assign sts.rd_zero   = (rd_ptr_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.bad_radix = (radix < RADIX_MIN) || (radix >= RADIX_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
		end else begin
			if (cmd.load) begin
				bit_cnt_q <= '0;
				wr_ptr_q  <= '0;
			end else if (cmd.div_step) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
			end else if (cmd.store) begin
				bit_cnt_q <= '0;
				wr_ptr_q  <= wr_ptr_q + PTR_W'(1);
				rd_ptr_q  <= wr_ptr_q;
			end else if (cmd.emit) begin
				rd_ptr_q <= rd_ptr_q - PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= (value >= VALUE_LIMIT) ? '0 : value;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[VALUE_W-2:0], sub_ok};
			rem_q <= sub_ok ? rem_sub[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
		end else if (cmd.store) begin
			rem_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem_q[wr_ptr_q] <= rem_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_digit_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= digit_to_char(rd_digit_q);
			out_last_q <= (rd_ptr_q == '0);
			out_bad_q  <= 1'b0;
		end else if (cmd.emit_err) begin
			out_char_q <= CHAR_ERROR;
			out_last_q <= 1'b1;
			out_bad_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;
	assign out_bad   = out_bad_q;

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_err) |-> sts.out_free)
		else $error("Output register overwritten before its transfer.");

	a_store_after_full_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> $past(cmd.div_step && sts.bit_last))
		else $error("Digit stored before the division finished.");

	a_last_digit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.rd_zero) |=> (out_valid_q && out_last_q && !out_bad_q))
		else $error("Final digit not marked as last.");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> (out_char_q == CHAR_ERROR && out_last_q && out_bad_q))
		else $error("Error result has wrong fields.");

endmodule

@@ tb/testbench.sv @@
// Self-checking stream and register testbench for the radix digit string converter core.
`timescale 1ns / 1ps

module testbench;

	localparam logic [2:0] RADIX_ADDR  = 3'd0;
	localparam logic [2:0] SPARE_ADDR  = 3'd4;
	localparam int         CYCLE_LIMIT = 1_200_000;
	localparam int         LONG_HOLD   = 400;
	localparam int         PHASES      = 7;
	localparam int         PHASE_ITEMS = 37;
	localparam int         SETTLE      = 30;
	localparam int         DIR_ROWS    = 23;
	localparam int         SHOW_LIMIT  = 40;

	typedef struct packed {
		logic [rdsc_pkg::CHAR_W-1:0] ch;
		logic                        last;
		logic                        bad;
	} digit_out_t;

	typedef struct {
		logic [rdsc_pkg::RADIX_W-1:0] radix;
		logic [rdsc_pkg::VALUE_W-1:0] value;
		bit                           typed;
		digit_out_t                   want;
	} dir_row_t;

	// Rows with a typed result produce exactly one transfer; the rest go through the predictor.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{6'd10, 13'd0,    1'b1, '{7'd48, 1'b1, 1'b0}},
		'{6'd10, 13'd4096, 1'b0, '0},
		'{6'd10, 13'd4097, 1'b1, '{7'd48, 1'b1, 1'b0}},
		'{6'd10, 13'd8191, 1'b1, '{7'd48, 1'b1, 1'b0}},
		'{6'd10, 13'd9,    1'b1, '{7'd57, 1'b1, 1'b0}},
		'{6'd10, 13'd5461, 1'b1, '{7'd48, 1'b1, 1'b0}},
		'{6'd10, 13'd2730, 1'b0, '0},
		'{6'd2,  13'd4096, 1'b0, '0},
		'{6'd2,  13'd1,    1'b1, '{7'd49, 1'b1, 1'b0}},
		'{6'd2,  13'd4095, 1'b0, '0},
		'{6'd2,  13'd8191, 1'b1, '{7'd48, 1'b1, 1'b0}},
		'{6'd32, 13'd31,   1'b1, '{7'd86, 1'b1, 1'b0}},
		'{6'd32, 13'd4096, 1'b0, '0},
		'{6'd32, 13'd1023, 1'b0, '0},
		'{6'd16, 13'd2748, 1'b0, '0},
		'{6'd3,  13'd4095, 1'b0, '0},
		'{6'd31, 13'd30,   1'b1, '{7'd85, 1'b1, 1'b0}},
		'{6'd33, 13'd5,    1'b1, '{7'd0,  1'b1, 1'b1}},
		'{6'd63, 13'd4096, 1'b1, '{7'd0,  1'b1, 1'b1}},
		'{6'd0,  13'd0,    1'b1, '{7'd0,  1'b1, 1'b1}},
		'{6'd1,  13'd7,    1'b1, '{7'd0,  1'b1, 1'b1}},
		'{6'd36, 13'd8191, 1'b1, '{7'd0,  1'b1, 1'b1}},
		'{6'd10, 13'd100,  1'b0, '0}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;    // [12:0] value, [15:13] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [6:0] digit_char, [7] zero
	logic        m_tlast;
	logic        m_tuser;          // [0] bad_radix
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	digit_out_t                   expected_digits [$];
	logic [rdsc_pkg::RADIX_W-1:0] radix_shadow  = rdsc_pkg::RADIX_RESET;
	bit                           steady        = 1'b0;
	bit                           long_hold_req = 1'b0;
	int                           hold_left     = 0;
	int                           errors        = 0;
	int                           items_sent    = 0;
	int                           digits_seen   = 0;
	int                           radix_writes  = 0;
	int                           cycle_count   = 0;

	radix_digit_string_converter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d digits outstanding.", cycle_count,
				expected_digits.size());
			$display("radix_digit_string_converter_core test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < SHOW_LIMIT) begin
			$display("Mismatch on %s at cycle %0d: got %0d, expected %0d.", what, cycle_count,
				got, want);
		end
		errors++;
	endtask

	// Expands one number into digit transfers, most significant first, or one error transfer.
	function automatic void predict_digits(input logic [rdsc_pkg::VALUE_W-1:0] v,
			input logic [rdsc_pkg::RADIX_W-1:0] base);
		string      symbols;
		int         num;
		int         n;
		int         b;
		int         rev [rdsc_pkg::MAX_DIGITS_DEF];
		digit_out_t d;
		symbols = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
		b = int'(base);
		if (b < 2 || b > 32) begin
			d.ch   = '0;
			d.last = 1'b1;
			d.bad  = 1'b1;
			expected_digits.push_back(d);
			return;
		end
		num = (v > 13'd4096) ? 0 : int'(v);
		n = 0;
		do begin
			rev[n] = num % b;
			num    = num / b;
			n++;
		end while (num != 0 && n < rdsc_pkg::MAX_DIGITS_DEF);
		for (int k = n - 1; k >= 0; k--) begin
			d.ch   = 7'(symbols[rev[k]]);
			d.last = (k == 0);
			d.bad  = 1'b0;
			expected_digits.push_back(d);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [rdsc_pkg::VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return 13'($urandom_range(0, 4096));
		if (r < 90) return 13'($urandom_range(4097, 8191));
		return 13'($urandom_range(0, 40));
	endfunction

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == RADIX_ADDR) begin
			radix_shadow = data[rdsc_pkg::RADIX_W-1:0];
		end
		radix_writes++;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_radix_readback();
		logic [31:0] got;
		reg_read(RADIX_ADDR, got);
		if (got[rdsc_pkg::RADIX_W-1:0] !== radix_shadow) begin
			report_mismatch("radix readback", int'(got[rdsc_pkg::RADIX_W-1:0]),
				int'(radix_shadow));
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_digits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_radix(input logic [rdsc_pkg::RADIX_W-1:0] r);
		logic [31:0] noise;
		drain_results();
		noise = $urandom;
		reg_write(RADIX_ADDR, {noise[31:6], r});
		check_radix_readback();
	endtask

	task automatic send_value(input logic [rdsc_pkg::VALUE_W-1:0] v, input bit typed,
			input digit_out_t want);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, v};
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		if (typed) begin
			expected_digits.push_back(want);
		end else begin
			predict_digits(v, radix_shadow);
		end
		items_sent++;
	endtask

	// Result side: random back-pressure, always ready while steady, plus one long hold on request.
	initial begin
		int r;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					hold_left = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		digit_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_digits.size() == 0) begin
				report_mismatch("unexpected transfer", int'(m_tdata), 0);
			end else begin
				want = expected_digits.pop_front();
				if (m_tdata[6:0] !== want.ch) begin
					report_mismatch("digit_char", int'(m_tdata[6:0]), int'(want.ch));
				end
				if (m_tlast !== want.last) begin
					report_mismatch("is_last", int'(m_tlast), int'(want.last));
				end
				if (m_tuser !== want.bad) begin
					report_mismatch("bad_radix", int'(m_tuser), int'(want.bad));
				end
				digits_seen++;
			end
		end
	end

	initial begin
		logic [rdsc_pkg::RADIX_W-1:0] r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_radix_readback();
		reg_write(SPARE_ADDR, 32'hFFFF_FFC3);
		check_radix_readback();

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].radix != radix_shadow) begin
				set_radix(dir_rows[i].radix);
			end
			send_value(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: r = 6'd2;
				1: r = 6'd32;
				3: begin
					case ($urandom_range(0, 2))
						0: r = 6'd0;
						1: r = 6'd1;
						default: r = 6'($urandom_range(33, 63));
					endcase
				end
				default: r = 6'($urandom_range(2, 32));
			endcase
			set_radix(r);
			steady = (p == 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 5) begin
					long_hold_req = 1'b1;
				end
				if (p == 5 && i == 20) begin
					drain_results();
				end
				send_value(pick_value(), 1'b0, '0);
			end
		end
		steady = 1'b0;

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("Converted %0d numbers (%0d from the directed table) into %0d checked digits.",
			items_sent, DIR_ROWS, digits_seen);
		$display("Used %0d register writes across bases 2 to 32 and unusable ones,",
			radix_writes);
		$display("with a %0d-cycle hold on the result side.", LONG_HOLD);
		if (errors == 0) begin
			$display("radix_digit_string_converter_core test passed");
		end else begin
			$display("radix_digit_string_converter_core test failed");
		end
		$finish;
	end

endmodule
